// ----- rtl/rsi_reversion_signal_top_defines.svh -----
// Assertion macros shared by the RSI reversion signal RTL.
`ifndef RSI_REVERSION_SIGNAL_TOP_DEFINES_SVH
`define RSI_REVERSION_SIGNAL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold in the same cycle as its trigger.
`define RSI_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsi_reversion_signal: same-cycle check failed");

// Condition that must hold in the cycle after its trigger.
`define RSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsi_reversion_signal: next-cycle check failed");

`else

`define RSI_ASSERT_IMPLIES(label, ante, cons)
`define RSI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/rsi_pkg.sv -----
// Types and constants shared by the RSI reversion signal modules.
package rsi_pkg;

    localparam int PRICE_IN_W = 32;
    localparam int POS_W      = 16;
    localparam int QUOT_W     = 15;
    localparam int LEVEL_W    = 15;
    localparam int WLEN_W     = 7;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 4;
    localparam int MID_DEPTH  = 2;

    // 25600 = 25 * 2^10, so the scaled numerator is a cheap constant product and a shift.
    localparam logic [QUOT_W-1:0] RSI_FULL      = 15'd25600;
    localparam int                RSI_ODD       = 25;
    localparam int                RSI_POW2_SHIFT = 10;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERBOUGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_QTY  = 2'd3;

    localparam logic [WLEN_W-1:0]  WINDOW_RESET     = 7'd14;
    localparam logic [LEVEL_W-1:0] OVERBOUGHT_RESET = 15'd17920;
    localparam logic [LEVEL_W-1:0] OVERSOLD_RESET   = 15'd7680;
    localparam logic [LEVEL_W-1:0] ENTRY_QTY_RESET  = 15'd100;

    typedef struct packed {
        logic [PRICE_IN_W-1:0]   close_price;
        logic signed [POS_W-1:0] position_qty;
    } bar_t;

    typedef struct packed {
        logic              rsi_valid;
        logic [QUOT_W-1:0] rsi_value;
        logic [1:0]        action;
        logic [14:0]       order_qty;
        logic [31:0]       trade_count;
        logic [QUOT_W-1:0] min_rsi;
        logic [QUOT_W-1:0] max_rsi;
    } result_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] overbought_level;
        logic [LEVEL_W-1:0] oversold_level;
        logic [LEVEL_W-1:0] entry_qty;
    } cfg_t;

endpackage

// ----- rtl/rsi_fifo.sv -----
// Short first-in first-out queue between the window front end and the RSI back end.
module rsi_fifo #(
    parameter int WIDTH = 93
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = $clog2(rsi_pkg::MID_DEPTH);
    localparam int CNT_W = $clog2(rsi_pkg::MID_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [rsi_pkg::MID_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(rsi_pkg::MID_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rsi_pkg::MID_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rsi_pkg::MID_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/rsi_front.sv -----
// Front end: takes bars, keeps the delta ring and the running gain and loss sums.
module rsi_front #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32,
    parameter int SUM_W      = 38
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  rsi_pkg::bar_t                       bar,
    input  logic [rsi_pkg::WLEN_W-1:0]          window_length,
    input  logic                                clear,
    output logic                                q_push,
    input  logic                                q_full,
    output logic [1+rsi_pkg::POS_W+2*SUM_W-1:0] q_data
);

    localparam int PB    = (PRICE_BITS > rsi_pkg::PRICE_IN_W) ? rsi_pkg::PRICE_IN_W : PRICE_BITS;
    localparam int DW    = PB + 1;
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int WL_W  = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_UPD  = 2'd1;
    localparam logic [1:0] F_EMIT = 2'd2;

    logic [1:0]                      state_reg,      state_next;
    logic [PTR_W-1:0]                ptr_reg,        ptr_next;
    logic [PB-1:0]                   last_price_reg, last_price_next;
    logic [CNT_W-1:0]                samples_reg,    samples_next;
    logic [SUM_W-1:0]                gain_reg,       gain_next;
    logic [SUM_W-1:0]                loss_reg,       loss_next;
    logic signed [DW-1:0]            delta_reg,      delta_next;
    logic                            drop_reg,       drop_next;
    logic signed [rsi_pkg::POS_W-1:0] pos_reg,       pos_next;

    logic signed [DW-1:0] ring [MAX_WINDOW];
    logic signed [DW-1:0] old_reg;
    logic                 ring_we;

    logic [WL_W-1:0]      w_eff;
    logic                 win_full;
    int                   old_idx;
    logic [PTR_W-1:0]     old_addr;
    logic [PB-1:0]        price_in;
    logic signed [DW-1:0] neg_old;
    logic signed [DW-1:0] neg_delta;
    logic [PB-1:0]        old_mag;
    logic [PB-1:0]        delta_mag;
    logic                 old_up;
    logic                 old_down;
    logic                 delta_up;
    logic                 delta_down;

    always_comb
    begin
        if (window_length == '0)
        begin
            w_eff = WL_W'(1);
        end
        else if (int'(window_length) > MAX_WINDOW)
        begin
            w_eff = WL_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WL_W'(window_length);
        end
    end

    assign win_full = (samples_reg >= CNT_W'(w_eff) + CNT_W'(1));
    assign price_in = bar.close_price[PB-1:0];

    // The oldest delta sits w entries behind the write pointer, modulo the ring size.
    always_comb
    begin
        old_idx = int'(ptr_reg) - int'(w_eff);
        if (old_idx < 0)
        begin
            old_idx = old_idx + MAX_WINDOW;
        end
        old_addr = PTR_W'(old_idx);
    end

    assign neg_old    = -old_reg;
    assign neg_delta  = -delta_reg;
    assign old_mag    = old_reg[DW-1] ? neg_old[PB-1:0] : old_reg[PB-1:0];
    assign delta_mag  = delta_reg[DW-1] ? neg_delta[PB-1:0] : delta_reg[PB-1:0];
    assign old_up     = drop_reg && !old_reg[DW-1] && (old_reg != '0);
    assign old_down   = drop_reg && old_reg[DW-1];
    assign delta_up   = !delta_reg[DW-1] && (delta_reg != '0);
    assign delta_down = delta_reg[DW-1];

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        last_price_next = last_price_reg;
        samples_next    = samples_reg;
        gain_next       = gain_reg;
        loss_next       = loss_reg;
        delta_next      = delta_reg;
        drop_next       = drop_reg;
        pos_next        = pos_reg;
        ring_we         = 1'b0;
        q_push          = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    pos_next        = bar.position_qty;
                    last_price_next = price_in;
                    if (samples_reg == '0)
                    begin
                        samples_next = CNT_W'(1);
                        state_next   = F_EMIT;
                    end
                    else
                    begin
                        delta_next = $signed({1'b0, price_in}) - $signed({1'b0, last_price_reg});
                        drop_next  = win_full;
                        state_next = F_UPD;
                    end
                end
            end
            F_UPD:
            begin
                gain_next = gain_reg - (old_up ? SUM_W'(old_mag) : '0)
                            + (delta_up ? SUM_W'(delta_mag) : '0);
                loss_next = loss_reg - (old_down ? SUM_W'(old_mag) : '0)
                            + (delta_down ? SUM_W'(delta_mag) : '0);
                ring_we   = 1'b1;
                ptr_next  = (ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);
                if (!drop_reg)
                begin
                    samples_next = samples_reg + CNT_W'(1);
                end
                state_next = F_EMIT;
            end
            F_EMIT:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (clear)
        begin
            ptr_next        = '0;
            last_price_next = '0;
            samples_next    = '0;
            gain_next       = '0;
            loss_next       = '0;
        end
    end

    assign full   = (state_reg != F_IDLE);
    assign q_data = {win_full, pos_reg, gain_reg, loss_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            ptr_reg        <= '0;
            last_price_reg <= '0;
            samples_reg    <= '0;
            gain_reg       <= '0;
            loss_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            last_price_reg <= last_price_next;
            samples_reg    <= samples_next;
            gain_reg       <= gain_next;
            loss_reg       <= loss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        drop_reg  <= drop_next;
        pos_reg   <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[ptr_reg] <= delta_reg;
        end
        old_reg <= ring[old_addr];
    end

endmodule

// ----- rtl/rsi_back.sv -----
// Back end: divides out the RSI, decides the order and keeps the statistics.
module rsi_back #(
    parameter int SUM_W = 38
) (
    input  logic                                clk,
    input  logic                                rst_n,
    output logic                                q_pop,
    input  logic                                q_empty,
    input  logic [1+rsi_pkg::POS_W+2*SUM_W-1:0] q_data,
    input  rsi_pkg::cfg_t                       cfg,
    output logic                                empty,
    input  logic                                pop,
    output rsi_pkg::result_t                    result
);

    localparam int QW    = rsi_pkg::QUOT_W;
    localparam int NUM_W = SUM_W + QW;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_PREP = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]                       state_reg,  state_next;
    logic [SUM_W-1:0]                 g_reg,      g_next;
    logic [SUM_W-1:0]                 l_reg,      l_next;
    logic [NUM_W-1:0]                 num_reg,    num_next;
    logic [NUM_W-1:0]                 den_reg,    den_next;
    logic [QW-1:0]                    quot_reg,   quot_next;
    logic [rsi_pkg::STEP_W-1:0]       step_reg,   step_next;
    logic signed [rsi_pkg::POS_W-1:0] pos_reg,    pos_next;
    logic [31:0]                      trades_reg, trades_next;
    logic [QW-1:0]                    low_reg,    low_next;
    logic [QW-1:0]                    high_reg,   high_next;
    logic                             out_valid_reg, out_valid_next;
    rsi_pkg::result_t                 result_reg, result_next;

    logic                             in_ready;
    logic signed [rsi_pkg::POS_W-1:0] in_pos;
    logic [SUM_W-1:0]                 in_gain;
    logic [SUM_W-1:0]                 in_loss;
    logic [SUM_W-1:0]                 total;
    logic                             fits;
    logic [1:0]                       act;
    logic [14:0]                      qty;

    assign {in_ready, in_pos, in_gain, in_loss} = q_data;
    assign total = g_reg + l_reg;
    assign fits  = (num_reg >= den_reg);
    assign q_pop = (state_reg == B_IDLE) && !q_empty && !out_valid_reg;

    always_comb
    begin
        if ((quot_reg < cfg.oversold_level) && (pos_reg == '0))
        begin
            act = rsi_pkg::ACT_BUY;
            qty = cfg.entry_qty;
        end
        else if ((quot_reg > cfg.overbought_level) && (pos_reg > 0))
        begin
            act = rsi_pkg::ACT_SELL;
            qty = pos_reg[14:0];
        end
        else
        begin
            act = rsi_pkg::ACT_NONE;
            qty = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        g_next         = g_reg;
        l_next         = l_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        trades_next    = trades_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    g_next   = in_gain;
                    l_next   = in_loss;
                    pos_next = in_pos;
                    if (!in_ready)
                    begin
                        result_next.rsi_valid   = 1'b0;
                        result_next.rsi_value   = '0;
                        result_next.action      = rsi_pkg::ACT_NONE;
                        result_next.order_qty   = '0;
                        result_next.trade_count = trades_reg;
                        result_next.min_rsi     = low_reg;
                        result_next.max_rsi     = high_reg;
                        out_valid_next          = 1'b1;
                    end
                    else if (in_loss == '0)
                    begin
                        quot_next  = rsi_pkg::RSI_FULL;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_PREP;
                    end
                end
            end
            B_PREP:
            begin
                num_next = (NUM_W'(g_reg) * NUM_W'(rsi_pkg::RSI_ODD)) << rsi_pkg::RSI_POW2_SHIFT;
                den_next = NUM_W'(total) << (QW - 1);
                quot_next  = '0;
                step_next  = rsi_pkg::STEP_W'(QW - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (fits)
                begin
                    num_next = num_reg - den_reg;
                end
                quot_next = {quot_reg[QW-2:0], fits};
                den_next  = den_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    step_next = step_reg - rsi_pkg::STEP_W'(1);
                end
            end
            B_DONE:
            begin
                if (quot_reg < low_reg)
                begin
                    low_next = quot_reg;
                end
                if (quot_reg > high_reg)
                begin
                    high_next = quot_reg;
                end
                if (act != rsi_pkg::ACT_NONE)
                begin
                    trades_next = trades_reg + 32'd1;
                end
                result_next.rsi_valid   = 1'b1;
                result_next.rsi_value   = quot_reg;
                result_next.action      = act;
                result_next.order_qty   = qty;
                result_next.trade_count = trades_next;
                result_next.min_rsi     = low_next;
                result_next.max_rsi     = high_next;
                out_valid_next          = 1'b1;
                state_next              = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            trades_reg    <= '0;
            low_reg       <= rsi_pkg::RSI_FULL;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            trades_reg    <= trades_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg      <= g_next;
        l_reg      <= l_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

endmodule

// ----- rtl/rsi_reversion_signal_top.sv -----
// Top level of the RSI mean-reversion signal block.
//
// The block takes one bar (closing price and current signed position) per input transfer
// and returns exactly one result transfer per bar, in order. A front end keeps a ring of
// the last window_length price deltas in an on-chip memory, with running gain and loss
// sums; it passes each bar through an update and an emit state (only the emit state on
// the very first bar after reset or after window_length is written), stalls while the
// queue is full, and hands the sums to the back end through a two-entry queue. Once
// window_length+1 prices have been seen, the back end forms RSI = floor(25600*G/(G+L))
// in 7.8 fixed point with a restoring divider that yields one quotient bit per cycle; a
// bar with a full window goes through take, prepare, fifteen divide steps and decide, a
// bar with no losses in the window skips the divider (take, decide), and a bar before
// the window is full is answered at the take step. The back end takes its next bar only
// once the output register is empty, so it cannot take a bar in the same cycle in which
// its last result is taken, and for bars with a full window the divider sets the
// sustained bar rate. A buy of entry_qty is issued when RSI is below oversold_level and
// the position is flat, a sell of the whole position when RSI is above overbought_level
// and the position is long. Results wait in an output register; the front end keeps
// taking bars meanwhile until the queue between the two halves fills. Writing
// window_length clears the window but keeps the trade count and the RSI minimum and
// maximum. Configuration must only be written while no bar is in flight. There is no
// clearing pass after reset: the oldest delta is used only from written ring entries.
`include "rsi_reversion_signal_top_defines.svh"

module rsi_reversion_signal_top #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  rsi_pkg::bar_t                     bar,
    output logic                              empty,
    input  logic                              pop,
    output rsi_pkg::result_t                  result,
    input  logic                              cfg_write,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Effective price width is capped by the 32-bit price field; the sums must hold a full
    // window of the largest possible price moves.
    localparam int PB     = (PRICE_BITS > rsi_pkg::PRICE_IN_W) ? rsi_pkg::PRICE_IN_W
                                                               : PRICE_BITS;
    localparam int SUM_W  = PB + $clog2(MAX_WINDOW);
    localparam int ITEM_W = 1 + rsi_pkg::POS_W + 2 * SUM_W;

    logic [rsi_pkg::WLEN_W-1:0]  window_reg;
    logic [rsi_pkg::LEVEL_W-1:0] overbought_reg;
    logic [rsi_pkg::LEVEL_W-1:0] oversold_reg;
    logic [rsi_pkg::LEVEL_W-1:0] entry_qty_reg;
    rsi_pkg::cfg_t               cfg;
    logic                        window_clear;

    logic              mid_push;
    logic              mid_full;
    logic [ITEM_W-1:0] mid_din;
    logic              mid_pop;
    logic              mid_empty;
    logic [ITEM_W-1:0] mid_dout;

    // Configuration registers. A write to the window length also restarts the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= rsi_pkg::WINDOW_RESET;
            overbought_reg <= rsi_pkg::OVERBOUGHT_RESET;
            oversold_reg   <= rsi_pkg::OVERSOLD_RESET;
            entry_qty_reg  <= rsi_pkg::ENTRY_QTY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rsi_pkg::REG_WINDOW:     window_reg     <= cfg_data[rsi_pkg::WLEN_W-1:0];
                rsi_pkg::REG_OVERBOUGHT: overbought_reg <= cfg_data;
                rsi_pkg::REG_OVERSOLD:   oversold_reg   <= cfg_data;
                rsi_pkg::REG_ENTRY_QTY:  entry_qty_reg  <= cfg_data;
            endcase
        end
    end

    assign window_clear         = cfg_write && (cfg_index == rsi_pkg::REG_WINDOW);
    assign cfg.overbought_level = overbought_reg;
    assign cfg.oversold_level   = oversold_reg;
    assign cfg.entry_qty        = entry_qty_reg;

    rsi_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .SUM_W      (SUM_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .bar           (bar),
        .window_length (window_reg),
        .clear         (window_clear),
        .q_push        (mid_push),
        .q_full        (mid_full),
        .q_data        (mid_din)
    );

    rsi_fifo #(
        .WIDTH (ITEM_W)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .din   (mid_din),
        .pop   (mid_pop),
        .empty (mid_empty),
        .dout  (mid_dout)
    );

    rsi_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_pop   (mid_pop),
        .q_empty (mid_empty),
        .q_data  (mid_dout),
        .cfg     (cfg),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // A valid RSI always lies between the running minimum and maximum that go with it.
    `RSI_ASSERT_IMPLIES(a_rsi_in_range, !empty && result.rsi_valid, (result.min_rsi <= result.rsi_value) && (result.rsi_value <= result.max_rsi) && (result.rsi_value <= rsi_pkg::RSI_FULL))

    // Before the window is full no RSI and no order may be reported.
    `RSI_ASSERT_IMPLIES(a_no_order_unfilled, !empty && !result.rsi_valid, (result.action == rsi_pkg::ACT_NONE) && (result.order_qty == '0) && (result.rsi_value == '0))

    // An order of the no-order kind carries no quantity.
    `RSI_ASSERT_IMPLIES(a_idle_qty_zero, !empty && (result.action == rsi_pkg::ACT_NONE), result.order_qty == '0)

    // The front end is busy in the cycle after it takes a bar.
    `RSI_ASSERT_NEXT(a_front_busy, push && !full, full)

endmodule
